@@ hdl/apd_pkg.sv @@
// Shared types, request codes and constants of the phase-angle dimmer.
package apd_pkg;

    // Channel count and derived index width
    localparam int CHANNELS = 16;
    localparam int CH_IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

    // Datapath widths
    localparam int DLY_W  = 16;
    localparam int LVL_W  = 8;
    localparam int PROD_W = 24;
    localparam int MASK_W = 16;

    // Number of channels as a value comparable with a 5-bit channel number
    localparam logic [4:0] CH_COUNT = 5'(CHANNELS);

    // Request codes
    localparam logic [1:0] REQ_TICK  = 2'd0;
    localparam logic [1:0] REQ_CROSS = 2'd1;
    localparam logic [1:0] REQ_WRITE = 2'd2;

    // Configuration register indexes
    localparam logic [1:0] CFG_MIN_DELAY = 2'd0;
    localparam logic [1:0] CFG_MAX_DELAY = 2'd1;
    localparam logic [1:0] CFG_DEBOUNCE  = 2'd2;

    // Configuration reset values
    localparam logic [DLY_W-1:0] RST_MIN_DELAY = 16'd500;
    localparam logic [DLY_W-1:0] RST_MAX_DELAY = 16'd8800;
    localparam logic [DLY_W-1:0] RST_DEBOUNCE  = 16'd1000;

    // Brightness full scale
    localparam logic [LVL_W-1:0] FULL_SCALE = 8'd255;

    // Input beat
    typedef struct packed {
        logic [1:0]       req_type;
        logic [3:0]       channel;
        logic [LVL_W-1:0] brightness;
        logic             last_of_frame;
    } t_apd_in;

    // Result beat
    typedef struct packed {
        logic [MASK_W-1:0] gate_mask;
        logic              crossing_accepted;
    } t_apd_out;

    // Load strobes of the arithmetic pipeline stages
    typedef struct packed {
        logic s2_load;
        logic s3_load;
    } t_pipe_adv;

endpackage

@@ hdl/apd_delay_unit.sv @@
// Delay arithmetic: max + trunc(level * (min - max) / 255) for on and off levels.
module apd_delay_unit (
    input  logic                      i_clk,
    input  apd_pkg::t_pipe_adv        i_adv,
    input  logic [apd_pkg::LVL_W-1:0] i_brightness,
    input  logic [apd_pkg::DLY_W-1:0] i_min_delay,
    input  logic [apd_pkg::DLY_W-1:0] i_max_delay,
    output logic [apd_pkg::DLY_W-1:0] o_on_delay,
    output logic [apd_pkg::DLY_W-1:0] o_off_delay
);
    import apd_pkg::*;

    logic              d_neg;
    logic [DLY_W-1:0]  d_mag;
    logic [LVL_W-1:0]  lvl_off;

    logic              r_neg2;
    logic [PROD_W-1:0] r_p2_on;
    logic [PROD_W-1:0] r_p2_off;

    logic              r_neg3;
    logic [PROD_W-1:0] r_p3_on;
    logic [PROD_W-1:0] r_p3_off;
    logic [DLY_W-1:0]  r_q0_on;
    logic [DLY_W-1:0]  r_q0_off;

    // Estimate p / 255 from below; result is the true quotient or one less
    function automatic logic [DLY_W-1:0] div255_est(input logic [PROD_W-1:0] p);
        logic [PROD_W:0] s;
        s = (PROD_W+1)'(p) + (PROD_W+1)'(p >> 8) + (PROD_W+1)'(p >> 16);
        return s[23:8];
    endfunction

    // Correct the estimate by one remainder compare, then apply it to max
    function automatic logic [DLY_W-1:0] delay_fix(
        input logic [PROD_W-1:0] p,
        input logic [DLY_W-1:0]  q0,
        input logic              neg,
        input logic [DLY_W-1:0]  maxd
    );
        logic [PROD_W-1:0] m;
        logic [PROD_W-1:0] r;
        logic [DLY_W-1:0]  q;
        m = {q0, 8'b0} - PROD_W'(q0);
        r = p - m;
        q = q0 + DLY_W'(r >= PROD_W'(FULL_SCALE));
        return neg ? (maxd - q) : (maxd + q);
    endfunction

    // Magnitude and sign of min - max
    always_comb begin
        d_neg   = (i_min_delay < i_max_delay);
        d_mag   = d_neg ? (i_max_delay - i_min_delay) : (i_min_delay - i_max_delay);
        lvl_off = i_brightness - LVL_W'(1);
    end

    // Multiply level by the delay span
    always_ff @(posedge i_clk) begin
        if (i_adv.s2_load) begin
            r_neg2   <= d_neg;
            r_p2_on  <= PROD_W'(i_brightness) * PROD_W'(d_mag);
            r_p2_off <= PROD_W'(lvl_off) * PROD_W'(d_mag);
        end
    end

    // Estimate the quotients
    always_ff @(posedge i_clk) begin
        if (i_adv.s3_load) begin
            r_neg3   <= r_neg2;
            r_p3_on  <= r_p2_on;
            r_p3_off <= r_p2_off;
            r_q0_on  <= div255_est(r_p2_on);
            r_q0_off <= div255_est(r_p2_off);
        end
    end

    assign o_on_delay  = delay_fix(r_p3_on, r_q0_on, r_neg3, i_max_delay);
    assign o_off_delay = delay_fix(r_p3_off, r_q0_off, r_neg3, i_max_delay);

endmodule

@@ hdl/apd_channel_core.sv @@
// Dimmer state: elapsed counter, pending and active delay sets, gates, result register.
module apd_channel_core (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_apply,
    input  apd_pkg::t_apd_in          i_item,
    input  logic [apd_pkg::DLY_W-1:0] i_on_delay,
    input  logic [apd_pkg::DLY_W-1:0] i_off_delay,
    input  logic [apd_pkg::DLY_W-1:0] i_debounce,
    output apd_pkg::t_apd_out         o_result
);
    import apd_pkg::*;

    logic [DLY_W-1:0]    r_elapsed;
    logic [DLY_W-1:0]    r_pend_on  [CHANNELS];
    logic [DLY_W-1:0]    r_pend_off [CHANNELS];
    logic [CHANNELS-1:0] r_pend_en;
    logic [DLY_W-1:0]    r_act_on   [CHANNELS];
    logic [DLY_W-1:0]    r_act_off  [CHANNELS];
    logic [CHANNELS-1:0] r_act_en;
    logic                r_committed;
    logic [CHANNELS-1:0] r_gate;
    t_apd_out            r_result;

    logic [DLY_W-1:0]    n_elapsed;
    logic [CHANNELS-1:0] n_pend_en;
    logic [CHANNELS-1:0] n_act_en;
    logic                n_committed;
    logic [CHANNELS-1:0] n_gate;
    logic                n_accepted;
    logic                do_swap;
    logic                do_pend_wr;
    logic                ch_ok;
    logic [CH_IDX_W-1:0] ch_idx;
    logic [DLY_W-1:0]    wr_on;
    logic [DLY_W-1:0]    wr_off;

    assign ch_ok  = ({1'b0, i_item.channel} < CH_COUNT);
    assign ch_idx = i_item.channel[CH_IDX_W-1:0];

    // Brightness zero stores zero delays
    assign wr_on  = (i_item.brightness == '0) ? '0 : i_on_delay;
    assign wr_off = (i_item.brightness == '0) ? '0 : i_off_delay;

    // Work out the effect of one beat
    always_comb begin
        n_elapsed   = r_elapsed;
        n_pend_en   = r_pend_en;
        n_act_en    = r_act_en;
        n_committed = r_committed;
        n_gate      = r_gate;
        n_accepted  = 1'b0;
        do_swap     = 1'b0;
        do_pend_wr  = 1'b0;
        case (i_item.req_type)
            REQ_TICK: begin
                n_elapsed = (r_elapsed == '1) ? r_elapsed : r_elapsed + DLY_W'(1);
                for (int i = 0; i < CHANNELS; i++) begin
                    if (r_act_en[i]) begin
                        if (n_elapsed == r_act_off[i]) begin
                            n_gate[i] = 1'b0;
                        end else if (n_elapsed == r_act_on[i]) begin
                            n_gate[i] = 1'b1;
                        end
                    end
                end
            end
            REQ_CROSS: begin
                if (r_elapsed >= i_debounce) begin
                    n_accepted = 1'b1;
                    n_elapsed  = '0;
                    if (r_committed) begin
                        do_swap     = 1'b1;
                        n_act_en    = r_pend_en;
                        n_committed = 1'b0;
                    end
                end
            end
            REQ_WRITE: begin
                if (ch_ok) begin
                    do_pend_wr        = 1'b1;
                    n_pend_en[ch_idx] = (i_item.brightness != '0);
                end
                if (i_item.last_of_frame) begin
                    n_committed = 1'b1;
                end
            end
            default: begin
            end
        endcase
    end

    // Hold control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_elapsed   <= '0;
            r_pend_en   <= '0;
            r_act_en    <= '0;
            r_committed <= 1'b0;
            r_gate      <= '0;
        end else if (i_apply) begin
            r_elapsed   <= n_elapsed;
            r_pend_en   <= n_pend_en;
            r_act_en    <= n_act_en;
            r_committed <= n_committed;
            r_gate      <= n_gate;
        end
    end

    // Store pending delays and copy them into the active set on a swap
    always_ff @(posedge i_clk) begin
        if (i_apply) begin
            if (do_pend_wr) begin
                r_pend_on[ch_idx]  <= wr_on;
                r_pend_off[ch_idx] <= wr_off;
            end
            if (do_swap) begin
                for (int i = 0; i < CHANNELS; i++) begin
                    r_act_on[i]  <= r_pend_on[i];
                    r_act_off[i] <= r_pend_off[i];
                end
            end
        end
    end

    // Capture the result beat
    always_ff @(posedge i_clk) begin
        if (i_apply) begin
            r_result.gate_mask         <= MASK_W'(n_gate);
            r_result.crossing_accepted <= n_accepted;
        end
    end

    assign o_result = r_result;

endmodule

@@ hdl/ac_phase_angle_dimmer.sv @@
// Multi-channel phase-angle dimmer: top level with input pipeline and output handshake.
// Every beat (tick, zero crossing or brightness write) yields one result beat holding
// the gate mask after the beat and a crossing-accepted flag. One beat is taken per clock
// cycle while o_stall is low; each passes the delay arithmetic (multiply stage, quotient
// estimate stage, correction and state update into the result register). Up to four
// beats are buffered, so input keeps flowing while a result waits until all are full.
// Configuration writes take effect at once and belong only to idle periods; brightness
// writes use the limits current at the multiply stage; max is read again at the update.
module ac_phase_angle_dimmer (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_valid,
    output logic                      o_stall,
    input  apd_pkg::t_apd_in          i_item,
    output logic                      o_valid,
    input  logic                      i_stall,
    output apd_pkg::t_apd_out         o_result,
    input  logic                      i_cfg_we,
    input  logic [1:0]                i_cfg_idx,
    input  logic [apd_pkg::DLY_W-1:0] i_cfg_data
);
    import apd_pkg::*;

    logic [DLY_W-1:0] r_min_delay;
    logic [DLY_W-1:0] r_max_delay;
    logic [DLY_W-1:0] r_debounce;

    logic     r_v1;
    logic     r_v2;
    logic     r_v3;
    logic     r_out_valid;
    t_apd_in  r_s1_item;
    t_apd_in  r_s2_item;
    t_apd_in  r_s3_item;

    logic      out_free;
    logic      free3;
    logic      free2;
    logic      free1;
    logic      mv3;
    t_pipe_adv adv;

    logic [DLY_W-1:0] on_delay;
    logic [DLY_W-1:0] off_delay;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_delay <= RST_MIN_DELAY;
            r_max_delay <= RST_MAX_DELAY;
            r_debounce  <= RST_DEBOUNCE;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_MIN_DELAY: r_min_delay <= i_cfg_data;
                CFG_MAX_DELAY: r_max_delay <= i_cfg_data;
                CFG_DEBOUNCE:  r_debounce  <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // Advance a stage when it is empty or the stage after it moves
    assign out_free    = !r_out_valid || !i_stall;
    assign free3       = !r_v3 || out_free;
    assign free2       = !r_v2 || free3;
    assign free1       = !r_v1 || free2;
    assign mv3         = r_v3 && out_free;
    assign adv.s2_load = free2;
    assign adv.s3_load = free3;
    assign o_stall     = !free1;
    assign o_valid     = r_out_valid;

    // Stage valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1        <= 1'b0;
            r_v2        <= 1'b0;
            r_v3        <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (free1) begin
                r_v1 <= i_valid;
            end
            if (free2) begin
                r_v2 <= r_v1;
            end
            if (free3) begin
                r_v3 <= r_v2;
            end
            if (out_free) begin
                r_out_valid <= r_v3;
            end
        end
    end

    // Carry the beat along with its arithmetic
    always_ff @(posedge i_clk) begin
        if (free1) begin
            r_s1_item <= i_item;
        end
        if (free2) begin
            r_s2_item <= r_s1_item;
        end
        if (free3) begin
            r_s3_item <= r_s2_item;
        end
    end

    apd_delay_unit u_delay (
        .i_clk        (i_clk),
        .i_adv        (adv),
        .i_brightness (r_s1_item.brightness),
        .i_min_delay  (r_min_delay),
        .i_max_delay  (r_max_delay),
        .o_on_delay   (on_delay),
        .o_off_delay  (off_delay)
    );

    apd_channel_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_apply     (mv3),
        .i_item      (r_s3_item),
        .i_on_delay  (on_delay),
        .i_off_delay (off_delay),
        .i_debounce  (r_debounce),
        .o_result    (o_result)
    );

endmodule
